@@ rtl/core/assert_macros.svh @@
// Assertion helpers shared by the core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is held.
`define ASSERT_SYNC(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds across reset.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/ted_pkg.sv @@
// ----------------------------------------------------------------------------
// ted_pkg
// Types and constants for the text encoding detector: payload structs, the
// per-byte class record passed from front to back, and code point limits.
// ----------------------------------------------------------------------------
`default_nettype none

package ted_pkg;

    localparam int QUEUE_DEPTH = 2;

    // verdict codes
    localparam logic ENC_UTF8 = 1'b0;
    localparam logic ENC_SJIS = 1'b1;

    // byte order mark codes
    localparam logic [1:0] BOM_NONE  = 2'd0;
    localparam logic [1:0] BOM_UTF8  = 2'd1;
    localparam logic [1:0] BOM_UTF16 = 2'd2;

    // code point limits
    localparam logic [20:0] CP_MIN_2   = 21'h00080;
    localparam logic [20:0] CP_MIN_3   = 21'h00800;
    localparam logic [20:0] CP_MIN_4   = 21'h10000;
    localparam logic [20:0] CP_MAX     = 21'h10FFFF;
    localparam logic [20:0] CP_SUR_LO  = 21'h0D800;
    localparam logic [20:0] CP_SUR_HI  = 21'h0DFFF;

    // byte order mark patterns
    localparam logic [15:0] LEAD_UTF8_BOM = 16'hEFBB;
    localparam logic [7:0]  UTF8_BOM_3RD  = 8'hBF;
    localparam logic [15:0] LEAD_UTF16_LE = 16'hFFFE;
    localparam logic [15:0] LEAD_UTF16_BE = 16'hFEFF;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in;

    typedef struct packed {
        logic       encoding;
        logic       utf8_ok;
        logic       sjis_ok;
        logic       ascii_only;
        logic [1:0] bom_kind;
    } t_out;

    // one classified byte
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
        logic [2:0] need;       // UTF-8 sequence length, 0 for an illegal lead
        logic [7:0] lead_part;  // payload bits of a multi-byte lead
        logic       is_cont;    // 10xxxxxx
        logic       sj_single;
        logic       sj_lead;
        logic       sj_trail;
    } t_cls;

endpackage

`default_nettype wire

@@ rtl/core/ted_front.sv @@
// ----------------------------------------------------------------------------
// ted_front
// Input stage: accepts bytes and classifies each one for the UTF-8 and
// Shift-JIS checks, holding the result in a register for the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module ted_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire ted_pkg::t_in  i_data,
    output logic               o_cls_valid,
    input  wire logic          i_cls_ready,
    output ted_pkg::t_cls      o_cls
);

    logic          r_valid;
    ted_pkg::t_cls r_cls;
    ted_pkg::t_cls n_cls;
    logic [7:0]    w_b;

    assign w_b = i_data.data_byte;

    always_comb begin
        n_cls           = '0;
        n_cls.data_byte = w_b;
        n_cls.last_byte = i_data.last_byte;
        priority if (!w_b[7]) begin
            n_cls.need = 3'd1;
        end else if (w_b[7:5] == 3'b110) begin
            n_cls.need      = 3'd2;
            n_cls.lead_part = {3'b000, w_b[4:0]};
        end else if (w_b[7:4] == 4'b1110) begin
            n_cls.need      = 3'd3;
            n_cls.lead_part = {4'b0000, w_b[3:0]};
        end else if (w_b[7:3] == 5'b11110) begin
            n_cls.need      = 3'd4;
            n_cls.lead_part = {5'b00000, w_b[2:0]};
        end else begin
            n_cls.need = 3'd0;
        end
        n_cls.is_cont   = (w_b[7:6] == 2'b10);
        n_cls.sj_single = (w_b <= 8'h7F) || (w_b >= 8'hA1 && w_b <= 8'hDF);
        n_cls.sj_lead   = (w_b >= 8'h81 && w_b <= 8'h9F) || (w_b >= 8'hE0 && w_b <= 8'hFC);
        n_cls.sj_trail  = (w_b >= 8'h40 && w_b <= 8'h7E) || (w_b >= 8'h80 && w_b <= 8'hFC);
    end

    assign o_ready     = !r_valid || i_cls_ready;
    assign o_cls_valid = r_valid;
    assign o_cls       = r_cls;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_cls <= n_cls;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/ted_queue.sv @@
// ----------------------------------------------------------------------------
// ted_queue
// Short FIFO of classified bytes between the front and back stages.
// ----------------------------------------------------------------------------
`default_nettype none

module ted_queue #(
    parameter int DEPTH = ted_pkg::QUEUE_DEPTH
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  wire ted_pkg::t_cls  i_cls,
    output logic                o_valid,
    input  wire logic           i_ready,
    output ted_pkg::t_cls       o_cls
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL      = CW'(DEPTH);

    ted_pkg::t_cls r_mem [DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_count;
    logic          w_push;
    logic          w_pop;

    assign o_ready = (r_count != FULL);
    assign o_valid = (r_count != '0);
    assign o_cls   = r_mem[r_rd];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == LAST_SLOT) ? '0 : r_wr + PW'(1);
            end
            if (w_pop) begin
                r_rd <= (r_rd == LAST_SLOT) ? '0 : r_rd + PW'(1);
            end
            unique case ({w_push, w_pop})
                2'b10:   r_count <= r_count + CW'(1);
                2'b01:   r_count <= r_count - CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_cls;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/ted_back.sv @@
// ----------------------------------------------------------------------------
// ted_back
// Check stage: runs the UTF-8, Shift-JIS, ASCII and BOM trackers over the
// classified bytes and registers the verdict on the last byte of a buffer.
// ----------------------------------------------------------------------------
`default_nettype none

module ted_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_cls_valid,
    output logic                o_cls_ready,
    input  wire ted_pkg::t_cls  i_cls,
    output logic                o_valid,
    input  wire logic           i_ready,
    output ted_pkg::t_out       o_data
);

    logic [1:0]    r_pos,   n_pos;
    logic [15:0]   r_lead,  n_lead;
    logic          r_ascii, n_ascii;
    logic          r_uflag, n_uflag;
    logic [1:0]    r_uleft, n_uleft;
    logic [2:0]    r_ulen,  n_ulen;
    logic [20:0]   r_upart, n_upart;
    logic          r_upend, n_upend;
    logic          r_sflag, n_sflag;
    logic          r_swant, n_swant;
    logic          r_out_valid;
    ted_pkg::t_out r_out;
    ted_pkg::t_out n_out;

    logic          w_take;
    logic          w_done;
    logic          w_bad;
    logic [7:0]    w_b;

    assign w_b         = i_cls.data_byte;
    // a non-final byte never touches the output register
    assign o_cls_ready = !i_cls.last_byte || !r_out_valid || i_ready;
    assign w_take      = i_cls_valid && o_cls_ready;
    assign w_done      = w_take && i_cls.last_byte;

    always_comb begin
        n_pos   = (r_pos == 2'd3) ? 2'd3 : r_pos + 2'd1;
        n_lead  = r_lead;
        n_ascii = r_ascii && !w_b[7];
        n_uflag = r_uflag;
        n_uleft = r_uleft;
        n_ulen  = r_ulen;
        n_upart = r_upart;
        n_upend = r_upend;
        n_sflag = r_sflag;
        n_swant = r_swant;
        w_bad   = 1'b0;

        unique case (r_pos)
            2'd0: n_lead = {w_b, 8'h00};
            2'd1: n_lead = {r_lead[15:8], w_b};
            2'd2: begin
                if (r_lead == ted_pkg::LEAD_UTF8_BOM && w_b != ted_pkg::UTF8_BOM_3RD) begin
                    n_lead = '0;
                end
            end
            default: n_lead = r_lead;
        endcase

        // UTF-8 tracker
        if (r_uleft != 2'd0) begin
            n_upend = r_upend || !i_cls.is_cont;
            n_upart = {r_upart[14:0], w_b[5:0]};
            n_uleft = 2'(r_uleft - 2'd1);
            if (n_uleft == 2'd0) begin
                w_bad = n_upend
                     || (r_ulen == 3'd2 && n_upart < ted_pkg::CP_MIN_2)
                     || (r_ulen == 3'd3 && n_upart < ted_pkg::CP_MIN_3)
                     || (r_ulen == 3'd4 && n_upart < ted_pkg::CP_MIN_4)
                     || (n_upart > ted_pkg::CP_MAX)
                     || (n_upart >= ted_pkg::CP_SUR_LO && n_upart <= ted_pkg::CP_SUR_HI);
                if (w_bad) begin
                    n_uflag = 1'b0;
                end
                n_upend = 1'b0;
                n_upart = '0;
                n_ulen  = '0;
            end
        end else if (i_cls.need == 3'd0) begin
            n_uflag = 1'b0;
        end else if (i_cls.need != 3'd1) begin
            n_ulen  = i_cls.need;
            n_uleft = 2'(i_cls.need - 3'd1);
            n_upart = {13'd0, i_cls.lead_part};
            n_upend = 1'b0;
        end

        // Shift-JIS tracker
        priority if (r_swant) begin
            if (!i_cls.sj_trail) begin
                n_sflag = 1'b0;
            end
            n_swant = 1'b0;
        end else if (i_cls.sj_single) begin
            n_swant = 1'b0;
        end else if (i_cls.sj_lead) begin
            n_swant = 1'b1;
        end else begin
            n_sflag = 1'b0;
        end

        n_out.utf8_ok    = n_uflag;
        n_out.sjis_ok    = n_sflag;
        n_out.ascii_only = n_ascii;
        priority if (n_pos == 2'd3 && n_lead == ted_pkg::LEAD_UTF8_BOM) begin
            n_out.bom_kind = ted_pkg::BOM_UTF8;
        end else if (n_pos >= 2'd2 && (n_lead == ted_pkg::LEAD_UTF16_LE
                                    || n_lead == ted_pkg::LEAD_UTF16_BE)) begin
            n_out.bom_kind = ted_pkg::BOM_UTF16;
        end else begin
            n_out.bom_kind = ted_pkg::BOM_NONE;
        end
        n_out.encoding = (n_out.bom_kind == ted_pkg::BOM_NONE && !n_ascii && !n_uflag
                          && n_sflag) ? ted_pkg::ENC_SJIS : ted_pkg::ENC_UTF8;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_done) begin
            // clear all trackers on reset and after the final byte
            r_pos   <= '0;
            r_lead  <= '0;
            r_ascii <= 1'b1;
            r_uflag <= 1'b1;
            r_uleft <= '0;
            r_ulen  <= '0;
            r_upart <= '0;
            r_upend <= 1'b0;
            r_sflag <= 1'b1;
            r_swant <= 1'b0;
        end else if (w_take) begin
            r_pos   <= n_pos;
            r_lead  <= n_lead;
            r_ascii <= n_ascii;
            r_uflag <= n_uflag;
            r_uleft <= n_uleft;
            r_ulen  <= n_ulen;
            r_upart <= n_upart;
            r_upend <= n_upend;
            r_sflag <= n_sflag;
            r_swant <= n_swant;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_done) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

`default_nettype wire

@@ rtl/core/text_encoding_detector_unit.sv @@
// ----------------------------------------------------------------------------
// text_encoding_detector_unit
// Classifies a byte buffer as UTF-8 or Shift-JIS and reports the checks.
// ----------------------------------------------------------------------------
// Bytes stream in one per cycle while o_ready is high, with last_byte set
// on the final one; a single verdict comes out for each buffer, nothing
// for the other bytes. Throughput is one byte per clock when neither side
// stalls, set by the tracker update in the check stage. The verdict passes
// through the input register, then the queue, then the output register,
// and waits there if the output is stalled. All trackers clear once the
// final byte has been checked, so the next buffer may follow straight
// away.
`default_nettype none

`include "assert_macros.svh"

module text_encoding_detector_unit #(
    parameter int QUEUE_DEPTH = ted_pkg::QUEUE_DEPTH
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire ted_pkg::t_in  i_data,
    output logic               o_valid,
    input  wire logic          i_ready,
    output ted_pkg::t_out      o_data
);

    logic          w_f_valid;
    logic          w_f_ready;
    ted_pkg::t_cls w_f_cls;
    logic          w_q_valid;
    logic          w_q_ready;
    ted_pkg::t_cls w_q_cls;

    ted_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data      (i_data),
        .o_cls_valid (w_f_valid),
        .i_cls_ready (w_f_ready),
        .o_cls       (w_f_cls)
    );

    ted_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_f_valid),
        .o_ready (w_f_ready),
        .i_cls   (w_f_cls),
        .o_valid (w_q_valid),
        .i_ready (w_q_ready),
        .o_cls   (w_q_cls)
    );

    ted_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cls_valid (w_q_valid),
        .o_cls_ready (w_q_ready),
        .i_cls       (w_q_cls),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_data      (o_data)
    );

    `ASSERT_ALWAYS(a_no_out_after_rst, i_clk, !i_rst_n |=> !o_valid, "result valid after reset")
    `ASSERT_SYNC(a_bom_code, i_clk, i_rst_n,
        o_valid |-> (o_data.bom_kind == ted_pkg::BOM_NONE || o_data.bom_kind == ted_pkg::BOM_UTF8
            || o_data.bom_kind == ted_pkg::BOM_UTF16),
        "bad bom code")
    `ASSERT_SYNC(a_sjis_verdict, i_clk, i_rst_n,
        o_valid && o_data.encoding == ted_pkg::ENC_SJIS |-> !o_data.utf8_ok && o_data.sjis_ok
            && !o_data.ascii_only && o_data.bom_kind == ted_pkg::BOM_NONE,
        "inconsistent verdict")
    `ASSERT_SYNC(a_ascii_passes, i_clk, i_rst_n,
        o_valid && o_data.ascii_only |-> o_data.utf8_ok && o_data.sjis_ok,
        "ascii buffer failed a check")

endmodule

`default_nettype wire

@@ bench/text_encoding_detector_unit_tb.sv @@
// ----------------------------------------------------------------------------
// text_encoding_detector_unit_tb
// Streams byte buffers into the encoding detector and checks every verdict.
// A scoreboard predicts each verdict on its own, with strict UTF-8, Shift-JIS,
// ASCII and byte order mark tracking. The stimulus starts with directed
// buffers. Random UTF-8, Shift-JIS, ASCII, BOM-led, truncated and noise
// buffers follow. Both handshake sides idle and stall in several phases.
// ----------------------------------------------------------------------------

class encoding_scoreboard;
    ted_pkg::t_out verdicts_due[$];
    int unsigned   mismatches;

    bit [1:0]  seen;
    bit [15:0] head;
    bit        ascii_ok;
    bit        utf8_ok;
    bit        sjis_ok;
    bit [1:0]  cont_left;
    bit [2:0]  seq_len;
    bit [20:0] cp_acc;
    bit        cont_bad;
    bit        trail_due;

    function new();
        restart();
        mismatches = 0;
    endfunction

    function void restart();
        seen      = 2'd0;
        head      = 16'h0000;
        ascii_ok  = 1'b1;
        utf8_ok   = 1'b1;
        sjis_ok   = 1'b1;
        cont_left = 2'd0;
        seq_len   = 3'd0;
        cp_acc    = 21'd0;
        cont_bad  = 1'b0;
        trail_due = 1'b0;
    endfunction

    function string show(ted_pkg::t_out v);
        return $sformatf("enc %0d utf8 %0d sjis %0d ascii %0d bom %0d",
                         v.encoding, v.utf8_ok, v.sjis_ok, v.ascii_only, v.bom_kind);
    endfunction

    function void flag(string msg);
        mismatches++;
        if (mismatches <= 10) $display("%s", msg);
    endfunction

    function void note_byte(ted_pkg::t_in item);
        bit [7:0]      b;
        bit            bad;
        ted_pkg::t_out verdict;
        b = item.data_byte;

        // keep the first two bytes; at the third, drop an EF BB head unless it is BF
        case (seen)
            2'd0: head = {b, 8'h00};
            2'd1: head[7:0] = b;
            2'd2: if (head == ted_pkg::LEAD_UTF8_BOM && b != ted_pkg::UTF8_BOM_3RD) head = 16'h0000;
            default: ;
        endcase
        if (seen != 2'd3) seen++;

        if (b[7]) ascii_ok = 1'b0;

        // strict UTF-8
        if (cont_left != 2'd0) begin
            if (b[7:6] != 2'b10) cont_bad = 1'b1;
            cp_acc = {cp_acc[14:0], b[5:0]};
            cont_left--;
            if (cont_left == 2'd0) begin
                bad = cont_bad;
                if (seq_len == 3'd2 && cp_acc < ted_pkg::CP_MIN_2) bad = 1'b1;
                if (seq_len == 3'd3 && cp_acc < ted_pkg::CP_MIN_3) bad = 1'b1;
                if (seq_len == 3'd4 && cp_acc < ted_pkg::CP_MIN_4) bad = 1'b1;
                if (cp_acc > ted_pkg::CP_MAX) bad = 1'b1;
                if (cp_acc >= ted_pkg::CP_SUR_LO && cp_acc <= ted_pkg::CP_SUR_HI) bad = 1'b1;
                if (bad) utf8_ok = 1'b0;
                cont_bad = 1'b0;
                cp_acc   = 21'd0;
                seq_len  = 3'd0;
            end
        end else if (b[7] == 1'b0) begin
            // single byte, nothing to track
        end else if (b[7:5] == 3'b110) begin
            seq_len = 3'd2; cont_left = 2'd1; cp_acc = {16'd0, b[4:0]}; cont_bad = 1'b0;
        end else if (b[7:4] == 4'b1110) begin
            seq_len = 3'd3; cont_left = 2'd2; cp_acc = {17'd0, b[3:0]}; cont_bad = 1'b0;
        end else if (b[7:3] == 5'b11110) begin
            seq_len = 3'd4; cont_left = 2'd3; cp_acc = {18'd0, b[2:0]}; cont_bad = 1'b0;
        end else begin
            utf8_ok = 1'b0;
        end

        // Shift-JIS lead/trail pairing
        if (trail_due) begin
            if (!((b >= 8'h40 && b <= 8'h7E) || (b >= 8'h80 && b <= 8'hFC))) sjis_ok = 1'b0;
            trail_due = 1'b0;
        end else if (b <= 8'h7F || (b >= 8'hA1 && b <= 8'hDF)) begin
            // single-byte character
        end else if ((b >= 8'h81 && b <= 8'h9F) || (b >= 8'hE0 && b <= 8'hFC)) begin
            trail_due = 1'b1;
        end else begin
            sjis_ok = 1'b0;
        end

        if (item.last_byte) begin
            verdict.bom_kind = ted_pkg::BOM_NONE;
            if (seen == 2'd3 && head == ted_pkg::LEAD_UTF8_BOM)
                verdict.bom_kind = ted_pkg::BOM_UTF8;
            else if (seen >= 2'd2 &&
                     (head == ted_pkg::LEAD_UTF16_LE || head == ted_pkg::LEAD_UTF16_BE))
                verdict.bom_kind = ted_pkg::BOM_UTF16;
            verdict.encoding = (verdict.bom_kind == ted_pkg::BOM_NONE && !ascii_ok &&
                                !utf8_ok && sjis_ok) ? ted_pkg::ENC_SJIS : ted_pkg::ENC_UTF8;
            verdict.utf8_ok    = utf8_ok;
            verdict.sjis_ok    = sjis_ok;
            verdict.ascii_only = ascii_ok;
            verdicts_due = {verdicts_due, verdict};
            restart();
        end
    endfunction

    function void check_verdict(ted_pkg::t_out got);
        ted_pkg::t_out want;
        if (verdicts_due.size() == 0) begin
            flag({"verdict with none due: ", show(got)});
            return;
        end
        want = verdicts_due.pop_front();
        if (got.encoding !== want.encoding || got.utf8_ok !== want.utf8_ok ||
            got.sjis_ok !== want.sjis_ok || got.ascii_only !== want.ascii_only ||
            got.bom_kind !== want.bom_kind)
            flag({"verdict mismatch: expected ", show(want), ", got ", show(got)});
    endfunction

    function void close_out();
        while (verdicts_due.size() != 0)
            flag({"verdict never arrived: ", show(verdicts_due.pop_front())});
    endfunction

    function int outstanding();
        return verdicts_due.size();
    endfunction
endclass

module text_encoding_detector_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 20;
    localparam int PHASE_BYTES    = 488;

    logic          i_clk   = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_valid = 1'b0;
    logic          i_ready = 1'b0;
    ted_pkg::t_in  i_data  = '0;
    logic          o_ready;
    logic          o_valid;
    ted_pkg::t_out o_data;

    int unsigned idle_pct  = 0;
    int unsigned stall_pct = 0;
    int unsigned quiet_cycles = 0;
    int unsigned sent_bytes   = 0;

    bit [7:0] buf_bytes[$];

    encoding_scoreboard sb = new();

    text_encoding_detector_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99, 0) >= stall_pct);
    end

    // note bytes, check verdicts, watch for a hang
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) sb.note_byte(i_data);
            if (o_valid && i_ready) sb.check_verdict(o_data);
            if ((i_valid && o_ready) || (o_valid && i_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
                $display("simulation failed");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    task automatic send_item(input bit [7:0] b, input bit last);
        while ($urandom_range(99, 0) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= '{data_byte: b, last_byte: last};
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    task automatic send_buffer();
        foreach (buf_bytes[k]) send_item(buf_bytes[k], k == buf_bytes.size() - 1);
        sent_bytes += buf_bytes.size();
    endtask

    // hold the sender until every verdict is in
    task automatic wait_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (sb.outstanding() != 0);
    endtask

    function automatic void add_byte(bit [7:0] b);
        buf_bytes = {buf_bytes, b};
    endfunction

    function automatic void put_utf8(bit [20:0] cp, int len);
        case (len)
            1: add_byte({1'b0, cp[6:0]});
            2: begin
                add_byte({3'b110, cp[10:6]});
                add_byte({2'b10, cp[5:0]});
            end
            3: begin
                add_byte({4'b1110, cp[15:12]});
                add_byte({2'b10, cp[11:6]});
                add_byte({2'b10, cp[5:0]});
            end
            default: begin
                add_byte({5'b11110, cp[20:18]});
                add_byte({2'b10, cp[17:12]});
                add_byte({2'b10, cp[11:6]});
                add_byte({2'b10, cp[5:0]});
            end
        endcase
    endfunction

    function automatic bit [20:0] random_cp(int len);
        case (len)
            1: return 21'($urandom_range(21'h7F, 0));
            2: return 21'($urandom_range(21'h7FF, 21'h80));
            3: return 21'($urandom_range(21'hFFFF, 21'h800));
            default: return 21'($urandom_range(21'h10FFFF, 21'h10000));
        endcase
    endfunction

    function automatic void add_utf8_char();
        int        pick;
        int        len;
        bit [20:0] cp;
        pick = $urandom_range(99, 0);
        len  = 1;
        if (pick < 30) begin
            len = 1;
        end else if (pick < 50) begin
            len = 2;
        end else if (pick < 70) begin
            len = 3;
        end else if (pick < 82) begin
            len = 4;
        end
        cp = random_cp(len);
        if (pick >= 82 && pick < 86) begin
            // overlong form
            len = $urandom_range(4, 2);
            cp  = 21'($urandom_range(len == 2 ? 21'h7F : len == 3 ? 21'h7FF : 21'hFFFF, 0));
        end else if (pick >= 86 && pick < 89) begin
            len = 3;
            cp  = 21'($urandom_range(ted_pkg::CP_SUR_HI, ted_pkg::CP_SUR_LO));
        end else if (pick >= 89 && pick < 92) begin
            len = 4;
            cp  = 21'($urandom_range(21'h1FFFFF, 21'h110000));
        end else if (pick >= 92 && pick < 96) begin
            case ($urandom_range(9, 0))
                0: begin len = 1; cp = 21'h7F; end
                1: begin len = 2; cp = 21'h80; end
                2: begin len = 2; cp = 21'h7FF; end
                3: begin len = 3; cp = 21'h800; end
                4: begin len = 3; cp = 21'hFFFF; end
                5: begin len = 3; cp = 21'hD7FF; end
                6: begin len = 3; cp = 21'hE000; end
                7: begin len = 4; cp = 21'h10000; end
                8: begin len = 4; cp = 21'h10FFFF; end
                default: begin len = 4; cp = 21'h110000; end
            endcase
        end else if (pick >= 96) begin
            len = $urandom_range(4, 2);
            cp  = random_cp(len);
        end
        put_utf8(cp, len);
        // break one continuation byte
        if (pick >= 96)
            buf_bytes[buf_bytes.size() - $urandom_range(len - 1, 1)] =
                8'($urandom_range(255, 0));
    endfunction

    function automatic bit [7:0] sjis_lead_byte();
        return $urandom_range(1, 0) ? 8'($urandom_range(8'h9F, 8'h81))
                                    : 8'($urandom_range(8'hFC, 8'hE0));
    endfunction

    function automatic void add_sjis_char();
        int pick;
        pick = $urandom_range(99, 0);
        if (pick < 30) begin
            add_byte(8'($urandom_range(8'h7F, 0)));
        end else if (pick < 45) begin
            add_byte(8'($urandom_range(8'hDF, 8'hA1)));
        end else if (pick < 90) begin
            add_byte(sjis_lead_byte());
            add_byte($urandom_range(1, 0) ? 8'($urandom_range(8'h7E, 8'h40))
                                          : 8'($urandom_range(8'hFC, 8'h80)));
        end else if (pick < 95) begin
            add_byte(sjis_lead_byte());
            case ($urandom_range(2, 0))
                0: add_byte(8'($urandom_range(8'h3F, 0)));
                1: add_byte(8'h7F);
                default: add_byte(8'($urandom_range(8'hFF, 8'hFD)));
            endcase
        end else begin
            case ($urandom_range(2, 0))
                0: add_byte(8'h80);
                1: add_byte(8'hA0);
                default: add_byte(8'($urandom_range(8'hFF, 8'hFD)));
            endcase
        end
    endfunction

    function automatic void make_buffer();
        int kind;
        int chars;
        int len;
        buf_bytes.delete();
        kind  = $urandom_range(99, 0);
        chars = ($urandom_range(9, 0) == 0) ? $urandom_range(20, 1) : $urandom_range(6, 1);
        if (kind < 35) begin
            repeat (chars) add_utf8_char();
        end else if (kind < 55) begin
            repeat (chars) add_sjis_char();
        end else if (kind < 63) begin
            repeat (chars) add_byte(8'($urandom_range(8'h7F, 0)));
        end else if (kind < 73) begin
            case ($urandom_range(4, 0))
                0: begin add_byte(8'hEF); add_byte(8'hBB);
                         add_byte(8'($urandom_range(255, 0))); end
                1: begin add_byte(8'hFF); add_byte(8'hFE); end
                2: begin add_byte(8'hFE); add_byte(8'hFF); end
                default: begin add_byte(8'hEF); add_byte(8'hBB);
                               add_byte(8'hBF); end
            endcase
            repeat ($urandom_range(4, 0)) begin
                if ($urandom_range(1, 0)) add_utf8_char();
                else add_sjis_char();
            end
        end else if (kind < 85) begin
            // end the buffer inside a sequence
            if ($urandom_range(1, 0)) begin
                repeat ($urandom_range(4, 0)) add_utf8_char();
                len = $urandom_range(4, 2);
                put_utf8(random_cp(len), len);
                repeat ($urandom_range(len - 1, 1)) void'(buf_bytes.pop_back());
                if (buf_bytes[buf_bytes.size() - 1][7:6] == 2'b10 && $urandom_range(1, 0))
                    buf_bytes[buf_bytes.size() - 1] = 8'($urandom_range(255, 0));
            end else begin
                repeat ($urandom_range(4, 0)) add_sjis_char();
                add_byte(sjis_lead_byte());
            end
        end else begin
            repeat ($urandom_range(8, 1)) add_byte(8'($urandom_range(255, 0)));
        end
    endfunction

    int unsigned sender_idle[4]    = '{0, 57, 0, 25};
    int unsigned receiver_stall[4] = '{0, 0, 57, 25};

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed buffers
        buf_bytes = '{8'hEF, 8'hBB, 8'hBF};       send_buffer();
        buf_bytes = '{8'hFF, 8'hFE};              send_buffer();
        buf_bytes = '{8'hFE, 8'hFF};              send_buffer();
        buf_bytes = '{8'hEF, 8'hBB};              send_buffer();  // too short for the BOM
        buf_bytes = '{8'hC0, 8'h80};              send_buffer();  // overlong
        buf_bytes = '{8'hED, 8'hA0, 8'h80};       send_buffer();  // surrogate
        buf_bytes = '{8'hF4, 8'h90, 8'h80, 8'h80}; send_buffer(); // above the top code point
        buf_bytes = '{8'hE3, 8'h41};              send_buffer();  // bad byte in a cut sequence
        buf_bytes = '{8'h82, 8'hA0, 8'hFC, 8'h7E}; send_buffer();
        buf_bytes = '{8'h00};                     send_buffer();
        buf_bytes = '{8'h80};                     send_buffer();
        wait_drained();

        for (int p = 0; p < 4; p++) begin
            idle_pct   = sender_idle[p];
            stall_pct  = receiver_stall[p];
            sent_bytes = 0;
            while (sent_bytes < PHASE_BYTES) begin
                make_buffer();
                send_buffer();
                if ($urandom_range(39, 0) == 0) wait_drained();
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        sb.close_out();
        if (sb.mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/ted_pkg.sv
rtl/core/ted_front.sv
rtl/core/ted_queue.sv
rtl/core/ted_back.sv
rtl/core/text_encoding_detector_unit.sv
bench/text_encoding_detector_unit_tb.sv
